/* rtl/core/ehvp_pkg.sv */
// shared types and constants for the ethernet header and vlan parser
`timescale 1ns / 1ps
`default_nettype none

package ehvp_pkg;

  // record kinds on the result channel
  typedef enum logic [1:0] {
    REC_HEADER         = 2'd0,
    REC_PAYLOAD        = 2'd1,
    REC_ERR_SHORT_HDR  = 2'd2,
    REC_ERR_SHORT_VLAN = 2'd3
  } rec_type_e;

  // byte positions within the header
  localparam logic [4:0] POS_DST_END  = 5'd6;
  localparam logic [4:0] POS_SRC_END  = 5'd12;
  localparam logic [4:0] POS_TYPE_LO  = 5'd13;
  localparam logic [4:0] POS_TYPE_END = 5'd14;
  localparam logic [4:0] POS_TCI_END  = 5'd16;
  localparam logic [4:0] POS_INNER_HI = 5'd16;
  localparam logic [4:0] POS_INNER_LO = 5'd17;
  localparam logic [4:0] POS_PAYLOAD  = 5'd18;

  // tag protocol identifiers and the length limit
  localparam logic [15:0] TPID_CTAG  = 16'h8100;
  localparam logic [15:0] TPID_STAG  = 16'h88A8;
  localparam logic [15:0] MAX_LENGTH = 16'd1500;

  // one result item
  typedef struct packed {
    rec_type_e   rtype;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic        tag_present;
    logic [15:0] tag_tpid;
    logic [2:0]  tag_prio;
    logic        tag_drop;
    logic [11:0] vlan_id;
    logic        is_length;
    logic [15:0] ethertype_len;
    logic [7:0]  payload_byte;
    logic        last;
  } rec_t;

endpackage

`default_nettype wire

/* rtl/core/ehvp_in_stage.sv */
// input register holding one frame byte and its last flag
`timescale 1ns / 1ps
`default_nettype none

module ehvp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] frame_byte_i,
  input  wire logic       frame_last_i,
  input  wire logic       step_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  // slot is free when empty or when its item moves on this cycle
  assign in_ready_o = !valid_q || step_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= frame_byte_i;
      last_q <= frame_last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

/* rtl/core/ehvp_parse.sv */
// header field capture and record forming for one byte per step
`timescale 1ns / 1ps
`default_nettype none

module ehvp_parse
  import ehvp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic            rec_valid_o,
  output rec_t            rec_o
);

  logic [4:0]  pos_q, pos_d;
  logic [47:0] dst_q, dst_d;
  logic [47:0] src_q, src_d;
  logic [15:0] outer_q, outer_d;
  logic [15:0] tci_q, tci_d;
  logic [7:0]  inner_hi_q, inner_hi_d;
  logic        tpid_hit;
  logic        hdr_done;
  logic [15:0] type_val;

  // shift the byte into whichever header field it belongs to
  always_comb begin
    dst_d      = dst_q;
    src_d      = src_q;
    outer_d    = outer_q;
    tci_d      = tci_q;
    inner_hi_d = inner_hi_q;
    if (pos_q < POS_DST_END) begin
      dst_d = {dst_q[39:0], byte_i};
    end else if (pos_q < POS_SRC_END) begin
      src_d = {src_q[39:0], byte_i};
    end else if (pos_q < POS_TYPE_END) begin
      outer_d = {outer_q[7:0], byte_i};
    end else if (pos_q < POS_TCI_END) begin
      tci_d = {tci_q[7:0], byte_i};
    end else if (pos_q == POS_INNER_HI) begin
      inner_hi_d = byte_i;
    end
  end

  assign tpid_hit = (outer_d == TPID_CTAG) || (outer_d == TPID_STAG);
  assign hdr_done = ((pos_q == POS_TYPE_LO) && !tpid_hit) || (pos_q == POS_INNER_LO);
  assign type_val = (pos_q == POS_INNER_LO) ? {inner_hi_d, byte_i} : outer_d;

  // record and next position
  always_comb begin
    rec_o       = '0;
    rec_valid_o = 1'b0;
    pos_d       = pos_q + 5'd1;
    if (pos_q >= POS_PAYLOAD) begin
      rec_valid_o        = 1'b1;
      rec_o.rtype        = REC_PAYLOAD;
      rec_o.payload_byte = byte_i;
      rec_o.last         = last_i;
      pos_d              = last_i ? 5'd0 : POS_PAYLOAD;
    end else if (hdr_done) begin
      rec_valid_o         = 1'b1;
      rec_o.rtype         = REC_HEADER;
      rec_o.dst_mac       = dst_d;
      rec_o.src_mac       = src_d;
      rec_o.is_length     = (type_val <= MAX_LENGTH);
      rec_o.ethertype_len = type_val;
      rec_o.last          = last_i;
      if (pos_q == POS_INNER_LO) begin
        rec_o.tag_present = 1'b1;
        rec_o.tag_tpid    = outer_d;
        rec_o.tag_prio    = tci_d[15:13];
        rec_o.tag_drop    = tci_d[12];
        rec_o.vlan_id     = tci_d[11:0];
      end
      pos_d = last_i ? 5'd0 : POS_PAYLOAD;
    end else if (last_i) begin
      rec_valid_o = 1'b1;
      rec_o.rtype = (pos_q < POS_TYPE_LO) ? REC_ERR_SHORT_HDR : REC_ERR_SHORT_VLAN;
      rec_o.last  = 1'b1;
      pos_d       = 5'd0;
    end
  end

  // parser state advances only when a byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 5'd0;
      dst_q      <= '0;
      src_q      <= '0;
      outer_q    <= '0;
      tci_q      <= '0;
      inner_hi_q <= '0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      dst_q      <= dst_d;
      src_q      <= src_d;
      outer_q    <= outer_d;
      tci_q      <= tci_d;
      inner_hi_q <= inner_hi_d;
    end
  end

`ifndef SYNTHESIS
  // position never runs past the payload phase
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_PAYLOAD)
    else $error("parser position out of range");

  // a final byte always sends the parser back to the frame start
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == 5'd0)
    else $error("parser did not restart after last byte");

  // a tagged header only appears on the last inner type byte
  a_vlan_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o && rec_o.rtype == REC_HEADER && rec_o.tag_present |->
      pos_q == POS_INNER_LO)
    else $error("vlan header at wrong position");

  // every final byte yields a record
  a_last_has_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |-> rec_valid_o && rec_o.last)
    else $error("final byte without final record");
`endif

endmodule

`default_nettype wire

/* rtl/core/ehvp_out_stage.sv */
// result register holding one record until it is taken
`timescale 1ns / 1ps
`default_nettype none

module ehvp_out_stage
  import ehvp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  rec_t      rec_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rec_t      rec_o
);

  logic valid_q, valid_d;
  rec_t rec_q;

  // room for a new record when empty or being drained now
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

/* rtl/core/ethernet_header_vlan_parser.sv */
// top level of the ethernet header parser with one vlan tag
`timescale 1ns / 1ps
`default_nettype none

// Takes a frame one byte per item and accepts a byte every cycle when the
// result side keeps up. Each byte passes an input register and then the
// field capture logic into a result register, so a record is offered only
// after its byte has left the input register. Header bytes give no record,
// except the one that completes the header (byte 13 untagged, byte 17 tagged)
// which gives the header record; every later byte gives a payload record, and
// a frame that ends inside the header gives one error record. A stalled result
// register holds the input register, which in turn drops in_ready_o.
module ethernet_header_vlan_parser
  import ehvp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       record_type_o,
  output logic [47:0]      dst_mac_o,
  output logic [47:0]      src_mac_o,
  output logic             tag_present_o,
  output logic [15:0]      tag_tpid_o,
  output logic [2:0]       tag_prio_o,
  output logic             tag_drop_o,
  output logic [11:0]      vlan_id_o,
  output logic             is_length_o,
  output logic [15:0]      ethertype_len_o,
  output logic [7:0]       payload_byte_o,
  output logic             record_last_o
);

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;
  logic       out_free;
  logic       step;
  logic       rec_valid;
  rec_t       rec;
  rec_t       rec_out;

  // a held item moves on whenever the result register can take its record
  assign step = stage_valid && out_free;

  ehvp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_byte_i (frame_byte_i),
    .frame_last_i (frame_last_i),
    .step_i       (step),
    .valid_o      (stage_valid),
    .byte_o       (stage_byte),
    .last_o       (stage_last)
  );

  ehvp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (stage_byte),
    .last_i      (stage_last),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  ehvp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && rec_valid),
    .rec_i       (rec),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec_out)
  );

  // unpack the record onto its ports
  assign record_type_o   = rec_out.rtype;
  assign dst_mac_o       = rec_out.dst_mac;
  assign src_mac_o       = rec_out.src_mac;
  assign tag_present_o   = rec_out.tag_present;
  assign tag_tpid_o      = rec_out.tag_tpid;
  assign tag_prio_o      = rec_out.tag_prio;
  assign tag_drop_o      = rec_out.tag_drop;
  assign vlan_id_o       = rec_out.vlan_id;
  assign is_length_o     = rec_out.is_length;
  assign ethertype_len_o = rec_out.ethertype_len;
  assign payload_byte_o  = rec_out.payload_byte;
  assign record_last_o   = rec_out.last;

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the ethernet header and vlan parser
`timescale 1ns / 1ps

module tb;
  import ehvp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_ITEMS   = 200;
  localparam int unsigned RAND_ITEMS   = 1120;
  localparam int unsigned MAX_SHOWN    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  frame_byte_i;
  logic        frame_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  record_type_o;
  logic [47:0] dst_mac_o;
  logic [47:0] src_mac_o;
  logic        tag_present_o;
  logic [15:0] tag_tpid_o;
  logic [2:0]  tag_prio_o;
  logic        tag_drop_o;
  logic [11:0] vlan_id_o;
  logic        is_length_o;
  logic [15:0] ethertype_len_o;
  logic [7:0]  payload_byte_o;
  logic        record_last_o;

  // pending frame bytes and expected records
  frame_item_t frame_bytes[$];
  rec_t        rec_expected[$];
  frame_item_t next_item;
  rec_t        rec_got;
  rec_t        rec_want;

  // parser state mirror
  logic [4:0]  hdr_pos;
  logic [47:0] dst_acc;
  logic [47:0] src_acc;
  logic [15:0] outer_type;
  logic [15:0] tci_acc;
  logic [7:0]  inner_hi;

  int unsigned bytes_in;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  bit          hold_done;
  bit          tail_phase;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned err_cnt;
  int unsigned mism_shown;

  ethernet_header_vlan_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .frame_byte_i    (frame_byte_i),
    .frame_last_i    (frame_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .record_type_o   (record_type_o),
    .dst_mac_o       (dst_mac_o),
    .src_mac_o       (src_mac_o),
    .tag_present_o   (tag_present_o),
    .tag_tpid_o      (tag_tpid_o),
    .tag_prio_o      (tag_prio_o),
    .tag_drop_o      (tag_drop_o),
    .vlan_id_o       (vlan_id_o),
    .is_length_o     (is_length_o),
    .ethertype_len_o (ethertype_len_o),
    .payload_byte_o  (payload_byte_o),
    .record_last_o   (record_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // advance the header parse by one byte and queue the record it causes
  task automatic parse_byte(input logic [7:0] b, input logic lst);
    rec_t        r;
    logic        tpid_hit;
    logic [15:0] t;
    r = '0;
    if (hdr_pos >= POS_PAYLOAD) begin
      r.rtype        = REC_PAYLOAD;
      r.payload_byte = b;
      r.last         = lst;
      hdr_pos        = lst ? 5'd0 : POS_PAYLOAD;
      rec_expected.push_back(r);
    end else begin
      if (hdr_pos < POS_DST_END) dst_acc = {dst_acc[39:0], b};
      else if (hdr_pos < POS_SRC_END) src_acc = {src_acc[39:0], b};
      else if (hdr_pos < POS_TYPE_END) outer_type = {outer_type[7:0], b};
      else if (hdr_pos < POS_TCI_END) tci_acc = {tci_acc[7:0], b};
      else if (hdr_pos == POS_INNER_HI) inner_hi = b;
      tpid_hit = (outer_type == TPID_CTAG) || (outer_type == TPID_STAG);
      if ((hdr_pos == POS_TYPE_LO && !tpid_hit) || hdr_pos == POS_INNER_LO) begin
        r.rtype   = REC_HEADER;
        r.dst_mac = dst_acc;
        r.src_mac = src_acc;
        if (hdr_pos == POS_INNER_LO) begin
          t             = {inner_hi, b};
          r.tag_present = 1'b1;
          r.tag_tpid    = outer_type;
          r.tag_prio    = tci_acc[15:13];
          r.tag_drop    = tci_acc[12];
          r.vlan_id     = tci_acc[11:0];
        end else begin
          t = outer_type;
        end
        r.is_length     = (t <= MAX_LENGTH);
        r.ethertype_len = t;
        r.last          = lst;
        hdr_pos         = lst ? 5'd0 : POS_PAYLOAD;
        rec_expected.push_back(r);
      end else if (lst) begin
        if (hdr_pos < POS_TYPE_LO) r.rtype = REC_ERR_SHORT_HDR;
        else r.rtype = REC_ERR_SHORT_VLAN;
        r.last  = 1'b1;
        hdr_pos = 5'd0;
        rec_expected.push_back(r);
      end else begin
        hdr_pos = hdr_pos + 5'd1;
      end
    end
  endtask

  // build one frame, optionally cut short after a given number of bytes
  task automatic add_frame(input logic [47:0] dst, input logic [47:0] src,
                           input bit with_tag, input logic [15:0] tpid,
                           input logic [15:0] tci, input logic [15:0] etype,
                           input int npay, input int cut);
    logic [7:0] fb[$];
    int         n;
    for (int i = 0; i < 6; i++) fb.push_back(dst[47-8*i -: 8]);
    for (int i = 0; i < 6; i++) fb.push_back(src[47-8*i -: 8]);
    if (with_tag) begin
      fb.push_back(tpid[15:8]);
      fb.push_back(tpid[7:0]);
      fb.push_back(tci[15:8]);
      fb.push_back(tci[7:0]);
    end
    fb.push_back(etype[15:8]);
    fb.push_back(etype[7:0]);
    for (int i = 0; i < npay; i++) fb.push_back(8'($urandom_range(0, 255)));
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) frame_bytes.push_back('{fb[i], (i == n - 1)});
  endtask

  // sender: drives queued bytes with random idle bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_valid_i) begin
          parse_byte(frame_byte_i, frame_last_i);
          bytes_in <= bytes_in + 1;
        end
        if (src_gap > 0) begin
          src_gap    <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (frame_bytes.size() > 0 && !tail_phase &&
                     $urandom_range(0, 9) == 0) begin
          src_gap    <= $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (frame_bytes.size() > 0) begin
          next_item    = frame_bytes.pop_front();
          in_valid_i   <= 1'b1;
          frame_byte_i <= next_item.data;
          frame_last_i <= next_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      tail_phase <= (frame_bytes.size() < TAIL_ITEMS);
    end
  end

  // receiver: checks each record against the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rec_got = '{rec_type_e'(record_type_o), dst_mac_o, src_mac_o, tag_present_o,
                    tag_tpid_o, tag_prio_o, tag_drop_o, vlan_id_o, is_length_o,
                    ethertype_len_o, payload_byte_o, record_last_o};
        if (rec_expected.size() == 0) begin
          err_cnt <= err_cnt + 1;
          if (mism_shown < MAX_SHOWN)
            $display("unexpected record: type %0d last %0d", record_type_o,
                     record_last_o);
          mism_shown <= mism_shown + 1;
        end else begin
          rec_want = rec_expected.pop_front();
          if (rec_got.rtype != rec_want.rtype || rec_got.dst_mac != rec_want.dst_mac ||
              rec_got.src_mac != rec_want.src_mac ||
              rec_got.tag_present != rec_want.tag_present ||
              rec_got.tag_tpid != rec_want.tag_tpid ||
              rec_got.tag_prio != rec_want.tag_prio ||
              rec_got.tag_drop != rec_want.tag_drop ||
              rec_got.vlan_id != rec_want.vlan_id ||
              rec_got.is_length != rec_want.is_length ||
              rec_got.ethertype_len != rec_want.ethertype_len ||
              rec_got.payload_byte != rec_want.payload_byte ||
              rec_got.last != rec_want.last) begin
            err_cnt <= err_cnt + 1;
            if (mism_shown < MAX_SHOWN) begin
              $display("mismatch exp: type %0d dst %h src %h vlan %0d tpid %h",
                       rec_want.rtype, rec_want.dst_mac, rec_want.src_mac,
                       rec_want.tag_present, rec_want.tag_tpid);
              $display("  exp: pcp %0d dei %0d vid %h len %0d tl %h pay %h last %0d",
                       rec_want.tag_prio, rec_want.tag_drop, rec_want.vlan_id,
                       rec_want.is_length, rec_want.ethertype_len,
                       rec_want.payload_byte, rec_want.last);
              $display("  got: type %0d dst %h src %h vlan %0d tpid %h",
                       rec_got.rtype, rec_got.dst_mac, rec_got.src_mac,
                       rec_got.tag_present, rec_got.tag_tpid);
              $display("  got: pcp %0d dei %0d vid %h len %0d tl %h pay %h last %0d",
                       rec_got.tag_prio, rec_got.tag_drop, rec_got.vlan_id,
                       rec_got.is_length, rec_got.ethertype_len,
                       rec_got.payload_byte, rec_got.last);
            end
            mism_shown <= mism_shown + 1;
          end
        end
      end
      // ready with random stall bursts and one long hold-off
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap     <= snk_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        snk_gap     <= $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // cycle count, long receiver hold-off and timeout
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (!hold_done && bytes_in >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [63:0] w;
    logic [47:0] dst;
    logic [47:0] src;
    logic [15:0] tpid;
    logic [15:0] etype;
    bit          with_tag;
    int          sel;
    int          npay;
    int          base;
    int          len;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    frame_byte_i = 8'h00;
    frame_last_i = 1'b0;
    out_ready_i  = 1'b0;
    hdr_pos      = '0;
    dst_acc      = '0;
    src_acc      = '0;
    outer_type   = '0;
    tci_acc      = '0;
    inner_hi     = '0;
    bytes_in     = 0;
    cycle_cnt    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    tail_phase   = 1'b0;
    src_gap      = 0;
    snk_gap      = 0;
    err_cnt      = 0;
    mism_shown   = 0;

    // directed frames
    // untagged minimum header, header record is the last record
    add_frame('0, '1, 1'b0, 16'h0, 16'h0, 16'h0800, 0, 0);
    // length at the limit, then one above, type field extremes
    add_frame('1, '0, 1'b0, 16'h0, 16'h0, MAX_LENGTH, 2, 0);
    add_frame(48'h0102_0304_0506, 48'ha1a2_a3a4_a5a6, 1'b0, 16'h0, 16'h0,
              MAX_LENGTH + 16'd1, 1, 0);
    add_frame(48'h0, 48'h1, 1'b0, 16'h0, 16'h0, 16'hFFFF, 0, 0);
    add_frame(48'h0, 48'h1, 1'b0, 16'h0, 16'h0, 16'h0000, 0, 0);
    // tagged minimum header, both tpids, tci extremes
    add_frame('1, '1, 1'b1, TPID_CTAG, 16'hFFFF, 16'h0000, 0, 0);
    add_frame(48'h0, 48'h0, 1'b1, TPID_STAG, 16'h0000, 16'h86DD, 2, 0);
    add_frame(48'h5, 48'h6, 1'b1, TPID_CTAG, 16'hA123, MAX_LENGTH, 1, 0);
    // frames too short for the header
    add_frame('1, '1, 1'b0, 16'h0, 16'h0, 16'h0800, 0, 1);
    add_frame('1, '1, 1'b0, 16'h0, 16'h0, 16'h0800, 0, 13);
    // tagged frames ending inside the tag or the inner type field
    add_frame('1, '1, 1'b1, TPID_CTAG, 16'h1234, 16'h0800, 0, 14);
    add_frame('1, '1, 1'b1, TPID_STAG, 16'h1234, 16'h0800, 0, 17);
    base = frame_bytes.size();

    // random frames, mostly well formed
    while (frame_bytes.size() < base + RAND_ITEMS) begin
      w   = {$urandom, $urandom};
      dst = w[47:0];
      w   = {$urandom, $urandom};
      src = w[47:0];
      with_tag = $urandom_range(0, 1);
      tpid     = $urandom_range(0, 1) ? TPID_CTAG : TPID_STAG;
      case ($urandom_range(0, 4))
        0: etype = 16'($urandom_range(0, 65535));
        1: etype = 16'($urandom_range(0, 1500));
        2: etype = MAX_LENGTH + 16'($urandom_range(0, 1));
        3: etype = 16'h0800;
        default: etype = tpid;
      endcase
      npay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        add_frame(dst, src, with_tag, tpid, 16'($urandom_range(0, 65535)), etype, npay, 0);
      end else if (sel < 92) begin
        len = with_tag ? 18 : 14;
        add_frame(dst, src, with_tag, tpid, 16'($urandom_range(0, 65535)), etype, 0,
                  $urandom_range(1, len - 1));
      end else begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
          frame_bytes.push_back('{8'($urandom_range(0, 255)), (i == len - 1)});
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for all items to drain, then let the design settle
    @(negedge clk_i);
    while (frame_bytes.size() > 0 || in_valid_i || rec_expected.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (rec_expected.size() > 0) err_cnt = err_cnt + 1;
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
